[rtl/lpdb_pkg.sv]
// Types and constants shared by the long-press detector.
`default_nettype none

package lpdb_pkg;

   // One-hot check phase.
   typedef enum logic [3:0] {
      PH_DEBOUNCE = 4'b0001,
      PH_HOLD     = 4'b0010,
      PH_NORMAL   = 4'b0100,
      PH_PROV     = 4'b1000
   } phase_type;

   // Verdict codes on the result word.
   typedef enum logic [1:0] {
      VERDICT_CHECKING = 2'd0,
      VERDICT_NORMAL   = 2'd1,
      VERDICT_PROV     = 2'd2
   } verdict_type;

   // Configuration register indexes.
   localparam int CSR_ADDR_WIDTH = 3;
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_DEBOUNCE = 3'd0,
      CSR_HOLD     = 3'd1,
      CSR_MARGIN   = 3'd2,
      CSR_BEEP_ON  = 3'd3,
      CSR_BEEP_OFF = 3'd4
   } csr_index_type;

   localparam int HELD_WIDTH = 17;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 24;

   typedef struct packed {
      logic [HELD_WIDTH-1:0] held_ticks;
      verdict_type           verdict;
      logic                  feedback;
   } result_type;

endpackage

`default_nettype wire

[rtl/long_press_detector_with_beep.sv]
// Long-press detector with beeper feedback, one button sample per word.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   req_tdata  {restart, button_level}
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata  {held_ticks, verdict, feedback}
//   csr      in         csr_valid/csr_ready     csr_addr, csr_wdata
//
// Each accepted word updates the phase and counters; its result is registered in the
// result register, or the skid register while rsp stalls. Words can be taken every
// cycle until both hold a waiting word. A result register with a skid register behind
// it keeps req_tready independent of rsp_tready.
// Reset is synchronous and loads the default timing values.
`default_nettype none

module long_press_detector_with_beep #(
   parameter int TIME_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // bit 0 button_level, bit 1 restart, then zero fill
   input  wire logic [lpdb_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // bit 0 feedback, bits 2:1 verdict, bits 19:3 held_ticks, then zero fill
   output logic [lpdb_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lpdb_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [TIME_WIDTH-1:0]               csr_wdata
);

   localparam int ELW = TIME_WIDTH + 1;

   // Configuration registers.
   logic [TIME_WIDTH-1:0] debounce_ff, hold_ff, margin_ff, beep_on_ticks_ff, beep_off_ticks_ff;

   // Check state.
   lpdb_pkg::phase_type   phase_ff, phase_in;
   logic [ELW-1:0]        elapsed_ff, elapsed_in;
   logic [TIME_WIDTH-1:0] beep_cnt_ff, beep_cnt_in;
   logic                  beep_on_ff, beep_on_in;

   // Output stage.
   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   lpdb_pkg::result_type  main_ff, main_in;
   lpdb_pkg::result_type  skid_ff, skid_in;
   lpdb_pkg::result_type  result;

   logic                  accept, pop;
   logic                  released, restart;
   logic [ELW-1:0]        total, elapsed_inc;
   logic [TIME_WIDTH-1:0] beep_inc, beep_len;
   logic [ELW+lpdb_pkg::HELD_WIDTH-1:0] held_ext;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = main_valid_ff && rsp_tready;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {{(lpdb_pkg::RSP_DATA_WIDTH - $bits(lpdb_pkg::result_type)){1'b0}},
                        main_ff};

   assign released = req_tdata[0];
   assign restart  = req_tdata[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff       <= TIME_WIDTH'(50);
         hold_ff           <= TIME_WIDTH'(5000);
         margin_ff         <= TIME_WIDTH'(500);
         beep_on_ticks_ff  <= TIME_WIDTH'(100);
         beep_off_ticks_ff <= TIME_WIDTH'(100);
      end else if (csr_valid && csr_ready) begin
         case (csr_addr)
            lpdb_pkg::CSR_DEBOUNCE: debounce_ff       <= csr_wdata;
            lpdb_pkg::CSR_HOLD:     hold_ff           <= csr_wdata;
            lpdb_pkg::CSR_MARGIN:   margin_ff         <= csr_wdata;
            lpdb_pkg::CSR_BEEP_ON:  beep_on_ticks_ff  <= csr_wdata;
            lpdb_pkg::CSR_BEEP_OFF: beep_off_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign total       = {1'b0, hold_ff} + {1'b0, margin_ff};
   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + ELW'(1);
   assign beep_inc    = (&beep_cnt_ff) ? beep_cnt_ff : beep_cnt_ff + TIME_WIDTH'(1);
   assign beep_len    = beep_on_ff ? beep_on_ticks_ff : beep_off_ticks_ff;

   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      beep_cnt_in = beep_cnt_ff;
      beep_on_in  = beep_on_ff;
      if (restart) begin
         phase_in    = lpdb_pkg::PH_DEBOUNCE;
         elapsed_in  = '0;
         beep_cnt_in = '0;
         beep_on_in  = 1'b0;
      end else begin
         case (phase_ff)
            lpdb_pkg::PH_DEBOUNCE: begin
               if (elapsed_ff >= {1'b0, debounce_ff}) begin
                  // The button sample at the end of debounce; this tick is time zero of the hold.
                  elapsed_in  = '0;
                  beep_cnt_in = '0;
                  beep_on_in  = 1'b0;
                  if (released) begin
                     phase_in = lpdb_pkg::PH_NORMAL;
                  end else if (total == '0) begin
                     phase_in = lpdb_pkg::PH_PROV;
                  end else begin
                     phase_in = lpdb_pkg::PH_HOLD;
                  end
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
            lpdb_pkg::PH_HOLD: begin
               elapsed_in  = elapsed_inc;
               beep_cnt_in = beep_inc;
               if (elapsed_inc >= total) begin
                  phase_in   = lpdb_pkg::PH_PROV;
                  beep_on_in = 1'b0;
               end else if (released) begin
                  phase_in   = lpdb_pkg::PH_NORMAL;
                  beep_on_in = 1'b0;
               end else if (beep_inc >= beep_len) begin
                  beep_on_in  = !beep_on_ff;
                  beep_cnt_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign held_ext = {{lpdb_pkg::HELD_WIDTH{1'b0}}, elapsed_in};

   always_comb begin
      result.feedback   = (phase_in == lpdb_pkg::PH_HOLD) && beep_on_in;
      result.held_ticks = (phase_in == lpdb_pkg::PH_DEBOUNCE) ?
                          '0 : held_ext[lpdb_pkg::HELD_WIDTH-1:0];
      case (phase_in)
         lpdb_pkg::PH_NORMAL: result.verdict = lpdb_pkg::VERDICT_NORMAL;
         lpdb_pkg::PH_PROV:   result.verdict = lpdb_pkg::VERDICT_PROV;
         default:             result.verdict = lpdb_pkg::VERDICT_CHECKING;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lpdb_pkg::PH_DEBOUNCE;
         elapsed_ff  <= '0;
         beep_cnt_ff <= '0;
         beep_on_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         beep_cnt_ff <= beep_cnt_in;
         beep_on_ff  <= beep_on_in;
      end
   end

   // The skid register only fills while the result register is stalled, and it
   // drains into the result register before any new word can be taken.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         main_valid_in = skid_valid_ff || accept;
         main_in       = skid_valid_ff ? skid_ff : result;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid register holds a word while the result register is empty");

   assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && main_ff.feedback) |-> main_ff.verdict == lpdb_pkg::VERDICT_CHECKING)
      else $error("feedback driven after a verdict was reached");

   assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == lpdb_pkg::PH_NORMAL || phase_ff == lpdb_pkg::PH_PROV)
       && !(accept && restart)) |=> $stable(phase_ff))
      else $error("verdict changed without a restart");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != lpdb_pkg::PH_HOLD) |-> !beep_on_ff)
      else $error("beeper left on outside the hold phase");

endmodule

`default_nettype wire

[tb/tb_long_press_detector_with_beep.sv]
// Self-checking testbench for the long-press detector: directed and random sample streams checked per word.
module tb_long_press_detector_with_beep;

   localparam int TIME_WIDTH = 16;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
   localparam logic [lpdb_pkg::HELD_WIDTH-1:0] ELAPSED_MAX = '1;
   localparam logic [lpdb_pkg::CSR_ADDR_WIDTH-1:0] CSR_UNUSED_LO = lpdb_pkg::CSR_BEEP_OFF + 3'd1;
   localparam logic [lpdb_pkg::CSR_ADDR_WIDTH-1:0] CSR_UNUSED_HI = '1;
   localparam int RANDOM_SAMPLES = 720;
   localparam int CYCLE_LIMIT = 4_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [lpdb_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lpdb_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lpdb_pkg::CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [TIME_WIDTH-1:0] csr_wdata = '0;

   long_press_detector_with_beep #(
      .TIME_WIDTH(TIME_WIDTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Button samples waiting to be sent, and results predicted but not yet seen.
   logic [lpdb_pkg::REQ_DATA_WIDTH-1:0] sample_words[$];
   lpdb_pkg::result_type expected_results[$];

   // Timing registers as the detector should hold them.
   logic [TIME_WIDTH-1:0] t_debounce, t_hold, t_margin, t_beep_on, t_beep_off;

   // Predicted check state.
   lpdb_pkg::phase_type det_phase;
   logic [lpdb_pkg::HELD_WIDTH-1:0] det_elapsed;
   logic [TIME_WIDTH-1:0] det_beep_count;
   logic det_beep_level;

   int error_count = 0;
   int cycle_count = 0;
   int sample_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int hold_off_left = 0;
   int hold_offs_done = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void clear_check();
      det_phase = lpdb_pkg::PH_DEBOUNCE;
      det_elapsed = '0;
      det_beep_count = '0;
      det_beep_level = 1'b0;
   endfunction

   function automatic lpdb_pkg::result_type step_detector(input logic released,
                                                           input logic restart);
      logic [lpdb_pkg::HELD_WIDTH-1:0] total;
      logic [TIME_WIDTH-1:0] beep_len;
      lpdb_pkg::result_type r;
      total = {1'b0, t_hold} + {1'b0, t_margin};
      if (restart) begin
         clear_check();
      end else if (det_phase == lpdb_pkg::PH_DEBOUNCE) begin
         // The sample is taken on the tick after the debounce count is reached.
         if (det_elapsed >= {1'b0, t_debounce}) begin
            det_elapsed = '0;
            det_beep_count = '0;
            det_beep_level = 1'b0;
            if (released) det_phase = lpdb_pkg::PH_NORMAL;
            else if (total == '0) det_phase = lpdb_pkg::PH_PROV;
            else det_phase = lpdb_pkg::PH_HOLD;
         end else if (det_elapsed != ELAPSED_MAX) begin
            det_elapsed = det_elapsed + 1'b1;
         end
      end else if (det_phase == lpdb_pkg::PH_HOLD) begin
         if (det_elapsed != ELAPSED_MAX) det_elapsed = det_elapsed + 1'b1;
         if (det_beep_count != TIME_MAX) det_beep_count = det_beep_count + 1'b1;
         if (det_elapsed >= total) begin
            det_phase = lpdb_pkg::PH_PROV;
            det_beep_level = 1'b0;
         end else if (released) begin
            det_phase = lpdb_pkg::PH_NORMAL;
            det_beep_level = 1'b0;
         end else begin
            beep_len = det_beep_level ? t_beep_on : t_beep_off;
            if (det_beep_count >= beep_len) begin
               det_beep_level = !det_beep_level;
               det_beep_count = '0;
            end
         end
      end
      r.feedback = (det_phase == lpdb_pkg::PH_HOLD) && det_beep_level;
      if (det_phase == lpdb_pkg::PH_NORMAL) r.verdict = lpdb_pkg::VERDICT_NORMAL;
      else if (det_phase == lpdb_pkg::PH_PROV) r.verdict = lpdb_pkg::VERDICT_PROV;
      else r.verdict = lpdb_pkg::VERDICT_CHECKING;
      r.held_ticks = (det_phase == lpdb_pkg::PH_DEBOUNCE) ? '0 : det_elapsed;
      return r;
   endfunction

   // Sender: bursts of words with random gaps; valid stays up until the word is taken.
   always @(posedge clock) begin
      logic fire;
      fire = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (fire) begin
            void'(sample_words.pop_front());
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
         if (req_tvalid && !fire) begin
            // Hold the current word.
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (sample_words.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= sample_words[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall patterns that change now and then, plus a couple of long hold-offs
   // once plenty of words are queued, so that the detector backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else if (hold_offs_done < 2 && sample_words.size() > 40) begin
         hold_off_left = 150;
         hold_offs_done++;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 2);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // Results are checked before the word taken at the same edge is predicted.
   always @(posedge clock) begin
      lpdb_pkg::result_type got;
      lpdb_pkg::result_type want;
      if (reset) begin
         t_debounce = 16'd50;
         t_hold = 16'd5000;
         t_margin = 16'd500;
         t_beep_on = 16'd100;
         t_beep_off = 16'd100;
         clear_check();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = lpdb_pkg::result_type'(rsp_tdata[$bits(lpdb_pkg::result_type)-1:0]);
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: nothing expected, got feedback %0b verdict %0d held %0d",
                        $time, got.feedback, got.verdict, got.held_ticks);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: expected feedback %0b verdict %0d held %0d, got %0b %0d %0d",
                           $time, want.feedback, want.verdict, want.held_ticks,
                           got.feedback, got.verdict, got.held_ticks);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(step_detector(req_tdata[0], req_tdata[1]));
      end
   end

   task automatic add_sample(input logic released, input logic restart);
      sample_words.push_back({{(lpdb_pkg::REQ_DATA_WIDTH-2){1'b0}}, restart, released});
      sample_count++;
   endtask

   // One check: restart, debounce ticks (button ignored), the sample, then the hold.
   task automatic queue_check(input int debounce_len, input bit pressed, input int hold_len,
                              input bit release_end);
      add_sample(1'($urandom_range(0, 1)), 1'b1);
      repeat (debounce_len) add_sample(1'($urandom_range(0, 1)), 1'b0);
      add_sample(!pressed, 1'b0);
      repeat (hold_len) add_sample(1'b0, 1'b0);
      if (release_end) add_sample(1'b1, 1'b0);
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (sample_words.size() != 0 || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Entered right after a rising edge; valid stays high across back-to-back writes.
   task automatic write_timing(input logic [TIME_WIDTH-1:0] debounce, hold, margin, on, off,
                               input bit poke_unused);
      logic [lpdb_pkg::CSR_ADDR_WIDTH-1:0] addr_list [6];
      logic [TIME_WIDTH-1:0] data_list [6];
      int n;
      addr_list[0] = lpdb_pkg::CSR_DEBOUNCE;  data_list[0] = debounce;
      addr_list[1] = lpdb_pkg::CSR_HOLD;      data_list[1] = hold;
      addr_list[2] = lpdb_pkg::CSR_MARGIN;    data_list[2] = margin;
      addr_list[3] = lpdb_pkg::CSR_BEEP_ON;   data_list[3] = on;
      addr_list[4] = lpdb_pkg::CSR_BEEP_OFF;  data_list[4] = off;
      n = 5;
      if (poke_unused) begin
         addr_list[5] = 3'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI));
         data_list[5] = TIME_WIDTH'($urandom_range(0, TIME_MAX));
         n = 6;
      end
      for (int k = 0; k < n; k++) begin
         csr_valid <= 1'b1;
         csr_addr <= addr_list[k];
         csr_wdata <= data_list[k];
         do @(posedge clock); while (!csr_ready);
         case (addr_list[k])
            lpdb_pkg::CSR_DEBOUNCE: t_debounce = data_list[k];
            lpdb_pkg::CSR_HOLD:     t_hold = data_list[k];
            lpdb_pkg::CSR_MARGIN:   t_margin = data_list[k];
            lpdb_pkg::CSR_BEEP_ON:  t_beep_on = data_list[k];
            lpdb_pkg::CSR_BEEP_OFF: t_beep_off = data_list[k];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [TIME_WIDTH-1:0] pick_time(input int short_max);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return TIME_MAX;
      if (roll == 1) return '0;
      return TIME_WIDTH'($urandom_range(0, short_max));
   endfunction

   initial begin
      int first_count;
      int total;
      int wait_len;
      logic [TIME_WIDTH-1:0] dbn;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Values after reset: still inside the long default debounce.
      repeat (4) add_sample(1'($urandom_range(0, 1)), 1'b0);
      wait_idle();

      // All timing at zero: the press seen at the sample decides provisioning at once,
      // and the verdict holds through a release.
      write_timing('0, '0, '0, '0, '0, 1'b1);
      queue_check(0, 1'b1, 0, 1'b1);
      queue_check(0, 1'b0, 0, 1'b0);
      wait_idle();

      // Short timing: a hold that completes, then one cut short by a release.
      write_timing(16'd1, 16'd4, 16'd2, 16'd1, 16'd2, 1'b1);
      queue_check(1, 1'b1, 7, 1'b1);
      queue_check(1, 1'b1, 3, 1'b1);
      add_sample(1'b0, 1'b1);
      add_sample(1'b0, 1'b0);
      wait_idle();

      // Hold, margin and beep lengths at their maximum: a wide total, cut short by a release.
      write_timing('0, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, 1'b0);
      queue_check(0, 1'b1, 60, 1'b1);
      wait_idle();

      first_count = sample_count;
      while (sample_count - first_count < RANDOM_SAMPLES) begin
         dbn = ($urandom_range(0, 19) == 0) ? 16'd60 : TIME_WIDTH'($urandom_range(0, 12));
         write_timing(dbn, pick_time(30), pick_time(10), pick_time(6), pick_time(6),
                      $urandom_range(0, 3) == 0);
         total = t_hold + t_margin;
         repeat ($urandom_range(2, 5)) begin
            // Mostly well-formed checks; now and then the sample lands off the debounce end.
            wait_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, dbn + 2) : dbn;
            queue_check(wait_len, $urandom_range(0, 3) != 0,
                        (total > 60) ? $urandom_range(0, 40) : $urandom_range(0, total + 3),
                        1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 3))
               add_sample(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
